@@ sv/ras_pkg.sv @@
// Shared types and constants for the ratiometric ADC scaler.
package ras_pkg;

    // action field codes
    localparam logic [1:0] ACT_REF_HI = 2'd0;
    localparam logic [1:0] ACT_REF_LO = 2'd1;
    localparam logic [1:0] ACT_DATA   = 2'd2;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int REF_W    = 32;
    localparam int RATE_W   = 33;
    localparam int RES_W    = 18;
    localparam int CNT_W    = 5;

    localparam logic [RES_W-1:0] POS_LIMIT = 18'd131071;
    localparam logic [RES_W-1:0] NEG_LIMIT = 18'd131072;
    localparam logic [RATE_W-1:0] RATE_RESET = 33'd2147;

    typedef enum logic [1:0] {
        OP_REF_HI,
        OP_REF_LO,
        OP_DATA
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [TIME_W-1:0]   stime;
        logic [SAMPLE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WMUL,
        ST_SMUL,
        ST_UPD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

@@ sv/ratiometric_adc_scaler_top.sv @@
// Top level of the ratiometric ADC scaler: front, queue and back.
//
//  channel   direction  handshake                 payload
//  sample    in         i_valid / o_stall         i_action, i_sample_time, i_sample_value
//  result    out        o_valid / i_stall         o_scaled_value, o_result_time, o_span_error
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (smooth_rate)
//
// A data beat goes through the back end as load, 18 restoring divide steps and
// result; an early saturation or a zero span skips the divide.
// A reference beat goes through load, weight multiply, step multiply and update.
// The queue takes beats while the back end works or the result waits; o_stall
// rises only when the queue is full. Reset is synchronous, active low, and
// clears the references to zero and smooth_rate to 2147.
module ratiometric_adc_scaler_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_action,
    input  logic [ras_pkg::TIME_W-1:0]    i_sample_time,
    input  logic [ras_pkg::SAMPLE_W-1:0]  i_sample_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ras_pkg::RES_W-1:0]     o_scaled_value,
    output logic [ras_pkg::TIME_W-1:0]    o_result_time,
    output logic                          o_span_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ras_pkg::RATE_W-1:0]    i_cfg_data
);

    ras_pkg::t_push  push;
    ras_pkg::t_entry head;
    ras_pkg::t_qstat qstat;
    logic            pop;

    assign o_cfg_ready = 1'b1;

    ras_front u_front (
        .i_valid        (i_valid),
        .i_action       (i_action),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .i_qstat        (qstat),
        .o_stall        (o_stall),
        .o_push         (push)
    );

    ras_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    ras_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_scaled_value (o_scaled_value),
        .o_result_time  (o_result_time),
        .o_span_error   (o_span_error)
    );

endmodule

@@ sv/ras_front.sv @@
// Input side: accepts sample beats and classifies them into queue entries.
module ras_front (
    input  logic                          i_valid,
    input  logic [1:0]                    i_action,
    input  logic [ras_pkg::TIME_W-1:0]    i_sample_time,
    input  logic [ras_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  ras_pkg::t_qstat               i_qstat,
    output logic                          o_stall,
    output ras_pkg::t_push                o_push
);

    logic accept;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_comb begin
        o_push.entry.stime = i_sample_time;
        o_push.entry.value = i_sample_value;
        o_push.entry.op    = ras_pkg::OP_DATA;
        o_push.valid       = 1'b0;
        unique case (i_action)
            ras_pkg::ACT_REF_HI: begin
                o_push.entry.op = ras_pkg::OP_REF_HI;
                o_push.valid    = accept;
            end
            ras_pkg::ACT_REF_LO: begin
                o_push.entry.op = ras_pkg::OP_REF_LO;
                o_push.valid    = accept;
            end
            ras_pkg::ACT_DATA: begin
                o_push.entry.op = ras_pkg::OP_DATA;
                o_push.valid    = accept;
            end
            // unused code: beat is taken and dropped
            default: o_push.valid = 1'b0;
        endcase
    end

endmodule

@@ sv/ras_queue.sv @@
// Short FIFO of classified entries between the front and the back.
module ras_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ras_pkg::t_push  i_push,
    input  logic            i_pop,
    output ras_pkg::t_entry o_head,
    output ras_pkg::t_qstat o_qstat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ras_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign do_push = i_push.valid && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_qstat.full)
        else $error("push while queue full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("pop from empty queue");

endmodule

@@ sv/ras_back.sv @@
// Execution side: reference smoothing, iterative ratio divide, result register.
module ras_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ras_pkg::RATE_W-1:0]    i_cfg_data,
    input  ras_pkg::t_entry               i_head,
    input  ras_pkg::t_qstat               i_qstat,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [ras_pkg::RES_W-1:0]     o_scaled_value,
    output logic [ras_pkg::TIME_W-1:0]    o_result_time,
    output logic                          o_span_error
);

    ras_pkg::t_state r_state, n_state;

    logic                       r_rate_full;
    logic [31:0]                r_rate;
    logic [ras_pkg::TIME_W-1:0] r_hi_time, r_lo_time;
    logic [ras_pkg::REF_W-1:0]  r_hi_val, r_lo_val;

    // working registers
    logic                       r_sel_hi;
    logic                       r_up;
    logic [31:0]                r_elapsed;
    logic [31:0]                r_d;
    logic [63:0]                r_prod;
    logic [31:0]                r_step;
    logic [ras_pkg::TIME_W-1:0] r_time;
    logic [31:0]                r_rem;
    logic [31:0]                r_ud;
    logic [17:0]                r_shin;
    logic [ras_pkg::RES_W-1:0]  r_q;
    logic [ras_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_neg;
    logic                       r_sat;
    logic                       r_err;

    logic                       r_out_valid;
    logic [ras_pkg::RES_W-1:0]  r_out_val;
    logic [ras_pkg::TIME_W-1:0] r_out_time;
    logic                       r_out_err;

    // decode of the queue head
    logic        is_data, sel_hi, up;
    logic [31:0] target, ref_t, ref_v, elapsed, d;
    logic [31:0] un, ud;
    logic        span_zero, num_neg, den_neg, sat;
    // divide step
    logic [33:0] trial;
    logic        qbit;
    // smoothing step
    logic        w_full;
    logic [63:0] dw;
    // result
    logic [ras_pkg::RES_W-1:0] limit, mag, res;
    logic        out_free;
    logic        load, finish;

    assign is_data = (i_head.op == ras_pkg::OP_DATA);
    assign sel_hi  = (i_head.op == ras_pkg::OP_REF_HI);
    assign target  = {i_head.value, 16'b0};
    assign ref_t   = sel_hi ? r_hi_time : r_lo_time;
    assign ref_v   = sel_hi ? r_hi_val : r_lo_val;
    assign elapsed = i_head.stime - ref_t;
    assign up      = (target >= ref_v);
    assign d       = up ? target - ref_v : ref_v - target;

    assign span_zero = (r_hi_val == r_lo_val);
    assign num_neg   = (target < r_lo_val);
    assign un        = num_neg ? r_lo_val - target : target - r_lo_val;
    assign den_neg   = (r_hi_val < r_lo_val);
    assign ud        = den_neg ? r_lo_val - r_hi_val : r_hi_val - r_lo_val;
    // quotient reaches 2^18 exactly when un >= 4 * ud
    assign sat       = ({2'b0, un} >= {ud, 2'b0});

    assign trial = {1'b0, r_rem, r_shin[17]} - {2'b0, r_ud};
    assign qbit  = !trial[33];

    // weight clamps to one; at full rate any nonzero elapsed does it
    assign w_full = r_rate_full ? (r_elapsed != '0) : (r_prod[63:32] != '0);
    assign dw     = {32'b0, r_d} * {32'b0, (r_rate_full ? 32'd0 : r_prod[31:0])};

    assign limit = r_neg ? ras_pkg::NEG_LIMIT : ras_pkg::POS_LIMIT;
    assign mag   = (r_sat || r_q > limit) ? limit : r_q;
    assign res   = r_err ? '0 : (r_neg ? ras_pkg::RES_W'(0) - mag : mag);

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ras_pkg::ST_IDLE: begin
                if (!i_qstat.empty) begin
                    if (is_data) begin
                        n_state = (span_zero || sat) ? ras_pkg::ST_DONE : ras_pkg::ST_DIV;
                    end else begin
                        n_state = ras_pkg::ST_WMUL;
                    end
                end
            end
            ras_pkg::ST_WMUL: n_state = ras_pkg::ST_SMUL;
            ras_pkg::ST_SMUL: n_state = ras_pkg::ST_UPD;
            ras_pkg::ST_UPD:  n_state = ras_pkg::ST_IDLE;
            ras_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ras_pkg::ST_DONE;
                end
            end
            ras_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ras_pkg::ST_IDLE;
                end
            end
            default: n_state = ras_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        load   = 1'b0;
        finish = 1'b0;
        unique case (r_state)
            ras_pkg::ST_IDLE: load   = !i_qstat.empty;
            ras_pkg::ST_DONE: finish = out_free;
            default: begin
                load   = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ras_pkg::ST_IDLE;
            r_rate_full <= ras_pkg::RATE_RESET[32];
            r_rate      <= ras_pkg::RATE_RESET[31:0];
            r_hi_time   <= '0;
            r_lo_time   <= '0;
            r_hi_val    <= '0;
            r_lo_val    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                // anything at or above 2^32 acts as full weight per tick
                r_rate_full <= i_cfg_data[32];
                r_rate      <= i_cfg_data[31:0];
            end
            if (r_state == ras_pkg::ST_UPD) begin
                if (r_sel_hi) begin
                    r_hi_time <= r_time;
                    r_hi_val  <= r_up ? r_hi_val + r_step : r_hi_val - r_step;
                end else begin
                    r_lo_time <= r_time;
                    r_lo_val  <= r_up ? r_lo_val + r_step : r_lo_val - r_step;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_time    <= i_head.stime;
            r_sel_hi  <= sel_hi;
            r_up      <= up;
            r_elapsed <= elapsed;
            r_d       <= d;
            r_err     <= span_zero;
            r_sat     <= sat;
            r_neg     <= num_neg != den_neg;
            r_rem     <= {2'b0, un[31:2]};
            r_shin    <= {un[1:0], 16'b0};
            r_ud      <= ud;
            r_cnt     <= ras_pkg::CNT_W'(ras_pkg::RES_W - 1);
        end
        if (r_state == ras_pkg::ST_WMUL) begin
            r_prod <= {32'b0, r_elapsed} * {32'b0, r_rate};
        end
        if (r_state == ras_pkg::ST_SMUL) begin
            r_step <= w_full ? r_d : dw[63:32];
        end
        if (r_state == ras_pkg::ST_DIV) begin
            r_rem  <= qbit ? trial[31:0] : {r_rem[30:0], r_shin[17]};
            r_shin <= {r_shin[16:0], 1'b0};
            r_q    <= {r_q[ras_pkg::RES_W-2:0], qbit};
            r_cnt  <= r_cnt - ras_pkg::CNT_W'(1);
        end
        if (finish) begin
            r_out_val  <= res;
            r_out_time <= r_time;
            r_out_err  <= r_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_scaled_value = r_out_val;
    assign o_result_time  = r_out_time;
    assign o_span_error   = r_out_err;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ras_pkg::ST_DIV |-> r_rem < r_ud)
        else $error("divider remainder not below divisor");

    a_span_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_error |-> o_scaled_value == '0)
        else $error("span error with nonzero result");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ras_pkg::ST_DIV && r_cnt == '0 |=> r_state == ras_pkg::ST_DONE)
        else $error("divide did not finish after last step");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ras_pkg::ST_IDLE)
        else $error("queue popped while busy");

endmodule
